// ===== design/tmfh_pkg.sv =====
// ----------------------------------------------------------------------------
// tmfh_pkg - shared types and constants of the tile map floor height block
// Tile entry layout, tile kinds, operation codes and fixed field widths.
// ----------------------------------------------------------------------------
package tmfh_pkg;

    // Fixed field widths
    localparam int POS_W   = 16;
    localparam int KIND_W  = 4;
    localparam int LEVEL_W = 16;
    localparam int RISE_W  = 8;
    localparam int OUT_W   = 25;

    // Operation codes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Tile kinds; codes without a member behave as open
    typedef enum logic [KIND_W-1:0] {
        KIND_SOLID   = 4'd0,
        KIND_OPEN    = 4'd1,
        KIND_DIAG_SE = 4'd2,
        KIND_DIAG_SW = 4'd3,
        KIND_DIAG_NW = 4'd4,
        KIND_DIAG_NE = 4'd5,
        KIND_SLOPE_N = 4'd6,
        KIND_SLOPE_S = 4'd7,
        KIND_SLOPE_E = 4'd8,
        KIND_SLOPE_W = 4'd9
    } t_tile_kind;

    // One tile store entry (44 bits)
    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [LEVEL_W-1:0] floor_lvl;
        logic [LEVEL_W-1:0] ceil_lvl;
        logic [RISE_W-1:0]  rise;
    } t_tile_entry;

endpackage

// ===== design/tmfh_height.sv =====
// ----------------------------------------------------------------------------
// tmfh_height - height of one tile at a fractional position
// Picks floor, ceiling, diagonal split or slope interpolation by tile kind.
// ----------------------------------------------------------------------------
module tmfh_height
    import tmfh_pkg::*;
#(
    parameter int FRAC_BITS = 8
) (
    input  t_tile_entry                    i_entry,
    input  logic [FRAC_BITS-1:0]           i_frac_x,
    input  logic [FRAC_BITS-1:0]           i_frac_y,
    output logic [LEVEL_W+FRAC_BITS+1:0]   o_height
);

    localparam int HW = LEVEL_W + FRAC_BITS + 2;
    localparam int PW = RISE_W + FRAC_BITS;
    localparam logic [FRAC_BITS:0] ONE_FIX = (FRAC_BITS+1)'(1) << FRAC_BITS;

    logic [HW-1:0]            floor_fix;
    logic [HW-1:0]            ceil_fix;
    logic [HW-1:0]            top_fix;
    logic [FRAC_BITS:0]       frac_sum;
    logic [FRAC_BITS-1:0]     frac_sel;
    logic [PW-1:0]            rise_prod;
    logic [HW-1:0]            rise_part;

    // Levels shifted into fixed point; top is floor plus one full rise
    assign floor_fix = HW'(i_entry.floor_lvl) << FRAC_BITS;
    assign ceil_fix  = HW'(i_entry.ceil_lvl) << FRAC_BITS;
    assign top_fix   = HW'({1'b0, i_entry.floor_lvl} + (LEVEL_W+1)'(i_entry.rise))
                       << FRAC_BITS;
    assign frac_sum  = (FRAC_BITS+1)'(i_frac_x) + (FRAC_BITS+1)'(i_frac_y);

    // North/south slopes run along y, east/west along x
    always_comb begin
        case (i_entry.kind)
            KIND_SLOPE_N, KIND_SLOPE_S: frac_sel = i_frac_y;
            default:                    frac_sel = i_frac_x;
        endcase
    end

    // Full-width rise times fraction
    assign rise_prod = PW'(i_entry.rise) * PW'(frac_sel);
    assign rise_part = HW'(rise_prod);

    // Kind select
    always_comb begin
        case (i_entry.kind)
            KIND_SOLID:   o_height = ceil_fix;
            KIND_DIAG_SE: o_height = (i_frac_x < i_frac_y) ? ceil_fix : floor_fix;
            KIND_DIAG_SW: o_height = (frac_sum > ONE_FIX)  ? ceil_fix : floor_fix;
            KIND_DIAG_NW: o_height = (i_frac_x > i_frac_y) ? ceil_fix : floor_fix;
            KIND_DIAG_NE: o_height = (frac_sum < ONE_FIX)  ? ceil_fix : floor_fix;
            KIND_SLOPE_N,
            KIND_SLOPE_E: o_height = floor_fix + rise_part;
            KIND_SLOPE_S,
            KIND_SLOPE_W: o_height = top_fix - rise_part;
            default:      o_height = floor_fix;
        endcase
    end

endmodule

// ===== design/tile_map_floor_height.sv =====
// ----------------------------------------------------------------------------
// tile_map_floor_height - tile map store with floor height queries
// Writes tile entries into a single-port-style store and answers height
// queries from it.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid/o_ready) carries one beat per item. A write beat
//   (operation 0) stores kind, floor, ceiling and rise at the tile selected
//   by bits above the fraction of x and y, wrapped to the map side. It
//   produces no output beat. A query beat (operation 1) returns one output
//   beat on o_valid/i_ready with the height in fixed point.
//   A query reads its tile entry into a register at the accept edge; the
//   height from it enters the output register when free and shows on o_valid.
//   Throughput: one item per cycle while the output is taken; the store
//   read at the accept edge and the height stage behind it set that figure.
//   A write followed by a query of the same tile sees the new entry, since
//   the write lands at the accept edge before the next read.
//   When the receiver stalls, the output register holds, the height stage
//   fills, and o_ready drops until the output register drains.
//   Reset clears the valid flags only; the tile store keeps no reset value
//   and a tile must be written before it is queried.
// ----------------------------------------------------------------------------
module tile_map_floor_height
    import tmfh_pkg::*;
#(
    parameter int MAP_SIDE  = 64,
    parameter int FRAC_BITS = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic                  i_operation,
    input  logic signed [POS_W-1:0] i_x_position,
    input  logic signed [POS_W-1:0] i_y_position,
    input  logic [KIND_W-1:0]     i_tile_kind,
    input  logic [LEVEL_W-1:0]    i_floor_level,
    input  logic [LEVEL_W-1:0]    i_ceiling_level,
    input  logic [RISE_W-1:0]     i_slope_rise,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [OUT_W-1:0]      o_height_value
);

    localparam int COORD_W = POS_W - FRAC_BITS;
    localparam int SIDE_W  = (MAP_SIDE > 2) ? $clog2(MAP_SIDE) : 1;
    localparam int DEPTH   = MAP_SIDE * MAP_SIDE;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int HW      = LEVEL_W + FRAC_BITS + 2;
    localparam logic [31:0] LIMIT = 32'(MAP_SIDE) << FRAC_BITS;

    // Tile coordinate modulo the map side, by restoring subtraction
    function automatic logic [SIDE_W-1:0] wrap_tile(input logic [COORD_W-1:0] v);
        logic [COORD_W-1:0] r;
        r = v;
        for (int k = COORD_W - 1; k >= 0; k--) begin
            if (32'(r) >= (32'(MAP_SIDE) << k)) begin
                r = r - COORD_W'(32'(MAP_SIDE) << k);
            end
        end
        return SIDE_W'(r);
    endfunction

    logic                   in_acc;
    logic                   out_free;
    logic [SIDE_W-1:0]      col;
    logic [SIDE_W-1:0]      row;
    logic [ADDR_W-1:0]      addr;
    logic                   out_of_map;
    t_tile_entry            wr_entry;
    logic [HW-1:0]          height;

    t_tile_entry            mem [DEPTH];
    t_tile_entry            r_rd_entry;
    logic [FRAC_BITS-1:0]   r_frac_x;
    logic [FRAC_BITS-1:0]   r_frac_y;
    logic                   r_s1_zero;
    logic                   r_s1_valid;
    logic                   r_out_valid;
    logic [OUT_W-1:0]       r_out_height;

    // Handshake
    assign out_free = !r_out_valid || i_ready;
    assign o_ready  = !r_s1_valid || out_free;
    assign in_acc   = i_valid && o_ready;

    // Store address from the tile bits of the position
    assign col  = wrap_tile(i_x_position[POS_W-1:FRAC_BITS]);
    assign row  = wrap_tile(i_y_position[POS_W-1:FRAC_BITS]);
    assign addr = ADDR_W'(ADDR_W'(row) * ADDR_W'(MAP_SIDE)) + ADDR_W'(col);

    // Negative or beyond the far edge reads as zero height
    assign out_of_map = i_x_position[POS_W-1] || i_y_position[POS_W-1] ||
                        (32'(unsigned'(i_x_position)) > LIMIT) ||
                        (32'(unsigned'(i_y_position)) > LIMIT);

    assign wr_entry = '{kind:      i_tile_kind,
                        floor_lvl: i_floor_level,
                        ceil_lvl:  i_ceiling_level,
                        rise:      i_slope_rise};

    // Tile store: write or registered read at the accept edge
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            if (i_operation == OP_WRITE) begin
                mem[addr] <= wr_entry;
            end else begin
                r_rd_entry <= mem[addr];
            end
        end
    end

    // Query side data held with the read
    always_ff @(posedge i_clk) begin
        if (in_acc && i_operation == OP_QUERY) begin
            r_frac_x  <= i_x_position[FRAC_BITS-1:0];
            r_frac_y  <= i_y_position[FRAC_BITS-1:0];
            r_s1_zero <= out_of_map;
        end
    end

    // Height stage
    tmfh_height #(
        .FRAC_BITS (FRAC_BITS)
    ) u_height (
        .i_entry  (r_rd_entry),
        .i_frac_x (r_frac_x),
        .i_frac_y (r_frac_y),
        .o_height (height)
    );

    // Stage and output valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_s1_valid <= (i_operation == OP_QUERY);
            end else if (out_free) begin
                r_s1_valid <= 1'b0;
            end
            if (out_free) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (out_free && r_s1_valid) begin
            r_out_height <= r_s1_zero ? '0 : OUT_W'(height);
        end
    end

    assign o_valid        = r_out_valid;
    assign o_height_value = r_out_height;

`ifndef SYNTH
    // A waiting query moves to the output when the output is free
    a_s1_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && out_free |=> r_out_valid)
        else $error("height stage did not advance");

    // A write beat leaves the height stage empty
    a_write_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_operation == OP_WRITE |=> !r_s1_valid)
        else $error("write beat raised a result");

    // A negative x query is forced to zero height
    a_neg_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_operation == OP_QUERY && i_x_position[POS_W-1] |=> r_s1_zero)
        else $error("negative position not flagged");

    // Stalled stage blocks new beats
    a_stall_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !out_free |-> !o_ready)
        else $error("accepted beat over stalled stage");
`endif

endmodule
